FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sm83_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_pkg
// opcode codes, flag layout and shared helpers for the sm83 alu/flag unit
// ----------------------------------------------------------------------------
package sm83_pkg;

	// flag bit positions inside the 4-bit flag word
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// main page opcode masks and codes
	localparam logic [7:0] MASK_R8     = 8'hc7;
	localparam logic [7:0] MASK_R16    = 8'hcf;
	localparam logic [7:0] MASK_CC     = 8'he7;
	localparam logic [7:0] OP_INC_R8   = 8'h04;
	localparam logic [7:0] OP_DEC_R8   = 8'h05;
	localparam logic [7:0] OP_DAA      = 8'h27;
	localparam logic [7:0] OP_RLCA     = 8'h07;
	localparam logic [7:0] OP_RRCA     = 8'h0f;
	localparam logic [7:0] OP_RLA      = 8'h17;
	localparam logic [7:0] OP_RRA      = 8'h1f;
	localparam logic [7:0] OP_CPL      = 8'h2f;
	localparam logic [7:0] OP_SCF      = 8'h37;
	localparam logic [7:0] OP_CCF      = 8'h3f;
	localparam logic [7:0] OP_INC_R16  = 8'h03;
	localparam logic [7:0] OP_DEC_R16  = 8'h0b;
	localparam logic [7:0] OP_ADD_HL   = 8'h09;
	localparam logic [7:0] OP_ADD_SP   = 8'he8;
	localparam logic [7:0] OP_LD_HL_SP = 8'hf8;
	localparam logic [7:0] OP_ALU_LO   = 8'h80;
	localparam logic [7:0] OP_ALU_HI   = 8'hbf;
	localparam logic [7:0] OP_ALU_IMM  = 8'hc6;
	localparam logic [7:0] OP_JR_CC    = 8'h20;
	localparam logic [7:0] OP_RET_CC   = 8'hc0;
	localparam logic [7:0] OP_JP_CC    = 8'hc2;
	localparam logic [7:0] OP_CALL_CC  = 8'hc4;
	localparam logic [7:0] OP_JR       = 8'h18;
	localparam logic [7:0] OP_JP       = 8'hc3;
	localparam logic [7:0] OP_RET      = 8'hc9;
	localparam logic [7:0] OP_CALL     = 8'hcd;

	// daa adjust values and thresholds
	localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
	localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
	localparam logic [7:0] DAA_HI_MAX  = 8'h99;
	localparam logic [3:0] DAA_LO_MAX  = 4'h9;

	typedef enum logic [2:0] {
		ALU_ADD, ALU_ADC, ALU_SUB, ALU_SBC, ALU_AND, ALU_XOR, ALU_OR, ALU_CP
	} alu_sel_t;

	typedef enum logic [2:0] {
		RS_RLC, RS_RRC, RS_RL, RS_RR, RS_SLA, RS_SRA, RS_SWAP, RS_SRL
	} rot_sel_t;

	typedef enum logic [1:0] {
		CB_ROT, CB_BIT, CB_RES, CB_SET
	} cb_grp_t;

	typedef enum logic [1:0] {
		CC_NZ, CC_Z, CC_NC, CC_C
	} cc_sel_t;

	typedef struct packed {
		logic [7:0]  byte_val;
		logic [15:0] word_val;
		logic [3:0]  flags;
		logic        cond;
		logic        unsup;
	} result_t;

	// rotate/shift/swap, returns {carry, value}
	function automatic logic [8:0] rot_shift(input rot_sel_t sel, input logic [7:0] v,
			input logic cin);
		logic [8:0] r;
		begin
			case (sel)
				RS_RLC:  r = {v[7], v[6:0], v[7]};
				RS_RRC:  r = {v[0], v[0], v[7:1]};
				RS_RL:   r = {v[7], v[6:0], cin};
				RS_RR:   r = {v[0], cin, v[7:1]};
				RS_SLA:  r = {v[7], v[6:0], 1'b0};
				RS_SRA:  r = {v[0], v[7], v[7:1]};
				RS_SWAP: r = {1'b0, v[3:0], v[7:4]};
				RS_SRL:  r = {v[0], 1'b0, v[7:1]};
				default: r = {1'b0, v};
			endcase
			return r;
		end
	endfunction

endpackage

FILE: hdl/sm83_alu_flag_unit.sv
`timescale 1ns / 1ps
// the accepted input word goes into the input register, the result is computed from it
// combinationally and then registered in the result register, which drives out_valid
// throughput: one word per cycle, limited only by out_ready backpressure
// the input and result registers let a new word enter while a result is still held
// reset: arst_n clears both stage valid bits asynchronously, payload is not reset
// ----------------------------------------------------------------------------
// sm83_alu_flag_unit
// arithmetic and flag unit of an sm83 cpu core: 8/16-bit results, flags, branch test
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sm83_alu_flag_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  req_type,
	input  logic        cb_page,
	input  logic [7:0]  acc,
	input  logic [3:0]  flags_in,
	input  logic [7:0]  operand,
	input  logic [15:0] wide_a,
	input  logic [15:0] wide_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  result_byte,
	output logic [15:0] result_word,
	output logic [3:0]  flags_out,
	output logic        cond_met,
	output logic        unsupported
);

	logic        valid_s1;
	logic        valid_s2;
	logic        load_s2;
	logic [7:0]  op_s1;
	logic        cb_s1;
	logic [7:0]  acc_s1;
	logic [3:0]  flags_s1;
	logic [7:0]  opnd_s1;
	logic [15:0] wa_s1;
	logic [15:0] wb_s1;
	sm83_pkg::result_t res;
	sm83_pkg::result_t res_s2;

	assign load_s2  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (load_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= req_type;
			cb_s1    <= cb_page;
			acc_s1   <= acc;
			flags_s1 <= flags_in;
			opnd_s1  <= operand;
			wa_s1    <= wide_a;
			wb_s1    <= wide_b;
		end
		if (load_s2 && valid_s1)
			res_s2 <= res;
	end

	always_comb begin
		sm83_pkg::alu_sel_t sel;
		logic        cin;
		logic [8:0]  sum9;
		logic [8:0]  diff9;
		logic [4:0]  nib_add;
		logic        h_sub;
		logic [7:0]  r8;
		logic        n_f;
		logic        h_f;
		logic        c_f;
		logic [8:0]  rs;
		logic [2:0]  bit_y;
		logic [7:0]  daa_off;
		logic        daa_c;
		logic [16:0] sum17;
		logic [12:0] sum13;
		logic [4:0]  sp_nib;
		logic [8:0]  sp_lo;

		sel     = sm83_pkg::alu_sel_t'(op_s1[5:3]);
		cin     = ((sel == sm83_pkg::ALU_ADC) || (sel == sm83_pkg::ALU_SBC)) ?
			flags_s1[sm83_pkg::FLAG_C] : 1'b0;
		sum9    = {1'b0, acc_s1} + {1'b0, opnd_s1} + {8'd0, cin};
		diff9   = {1'b0, acc_s1} - {1'b0, opnd_s1} - {8'd0, cin};
		nib_add = {1'b0, acc_s1[3:0]} + {1'b0, opnd_s1[3:0]} + {4'd0, cin};
		h_sub   = {1'b0, acc_s1[3:0]} < ({1'b0, opnd_s1[3:0]} + {4'd0, cin});
		bit_y   = op_s1[5:3];
		sum17   = {1'b0, wa_s1} + {1'b0, wb_s1};
		sum13   = {1'b0, wa_s1[11:0]} + {1'b0, wb_s1[11:0]};
		sp_nib  = {1'b0, wa_s1[3:0]} + {1'b0, opnd_s1[3:0]};
		sp_lo   = {1'b0, wa_s1[7:0]} + {1'b0, opnd_s1};
		r8      = 8'd0;
		n_f     = 1'b0;
		h_f     = 1'b0;
		c_f     = 1'b0;
		rs      = 9'd0;
		daa_off = 8'd0;
		daa_c   = flags_s1[sm83_pkg::FLAG_C];

		res          = '0;
		res.flags    = flags_s1;

		if (cb_s1) begin
			case (sm83_pkg::cb_grp_t'(op_s1[7:6]))
				sm83_pkg::CB_BIT: begin
					res.byte_val = opnd_s1;
					res.flags    = {~opnd_s1[bit_y], 1'b0, 1'b1, flags_s1[sm83_pkg::FLAG_C]};
				end
				sm83_pkg::CB_RES: res.byte_val = opnd_s1 & ~(8'h01 << bit_y);
				sm83_pkg::CB_SET: res.byte_val = opnd_s1 | (8'h01 << bit_y);
				default: begin
					rs = sm83_pkg::rot_shift(sm83_pkg::rot_sel_t'(bit_y), opnd_s1,
						flags_s1[sm83_pkg::FLAG_C]);
					res.byte_val = rs[7:0];
					res.flags    = {rs[7:0] == 8'd0, 1'b0, 1'b0, rs[8]};
				end
			endcase
		end else if ((op_s1 & sm83_pkg::MASK_R8) == sm83_pkg::OP_INC_R8) begin
			res.byte_val = opnd_s1 + 8'd1;
			res.flags    = {res.byte_val == 8'd0, 1'b0, opnd_s1[3:0] == 4'hf,
				flags_s1[sm83_pkg::FLAG_C]};
		end else if ((op_s1 & sm83_pkg::MASK_R8) == sm83_pkg::OP_DEC_R8) begin
			res.byte_val = opnd_s1 - 8'd1;
			res.flags    = {res.byte_val == 8'd0, 1'b1, opnd_s1[3:0] == 4'h0,
				flags_s1[sm83_pkg::FLAG_C]};
		end else if (op_s1 == sm83_pkg::OP_DAA) begin
			n_f = flags_s1[sm83_pkg::FLAG_N];
			if (flags_s1[sm83_pkg::FLAG_H] || (!n_f && (acc_s1[3:0] > sm83_pkg::DAA_LO_MAX)))
				daa_off = daa_off | sm83_pkg::DAA_LO_ADJ;
			if (daa_c || (!n_f && (acc_s1 > sm83_pkg::DAA_HI_MAX))) begin
				daa_off = daa_off | sm83_pkg::DAA_HI_ADJ;
				daa_c   = 1'b1;
			end
			res.byte_val = n_f ? (acc_s1 - daa_off) : (acc_s1 + daa_off);
			res.flags    = {res.byte_val == 8'd0, n_f, 1'b0, daa_c};
		end else if ((op_s1 == sm83_pkg::OP_RLCA) || (op_s1 == sm83_pkg::OP_RRCA) ||
				(op_s1 == sm83_pkg::OP_RLA) || (op_s1 == sm83_pkg::OP_RRA)) begin
			rs = sm83_pkg::rot_shift(sm83_pkg::rot_sel_t'(bit_y), acc_s1,
				flags_s1[sm83_pkg::FLAG_C]);
			res.byte_val = rs[7:0];
			res.flags    = {3'b000, rs[8]};
		end else if (op_s1 == sm83_pkg::OP_CPL) begin
			res.byte_val = ~acc_s1;
			res.flags    = {flags_s1[sm83_pkg::FLAG_Z], 1'b1, 1'b1, flags_s1[sm83_pkg::FLAG_C]};
		end else if (op_s1 == sm83_pkg::OP_SCF) begin
			res.byte_val = acc_s1;
			res.flags    = {flags_s1[sm83_pkg::FLAG_Z], 3'b001};
		end else if (op_s1 == sm83_pkg::OP_CCF) begin
			res.byte_val = acc_s1;
			res.flags    = {flags_s1[sm83_pkg::FLAG_Z], 2'b00, ~flags_s1[sm83_pkg::FLAG_C]};
		end else if ((op_s1 & sm83_pkg::MASK_R16) == sm83_pkg::OP_INC_R16) begin
			res.word_val = wa_s1 + 16'd1;
		end else if ((op_s1 & sm83_pkg::MASK_R16) == sm83_pkg::OP_DEC_R16) begin
			res.word_val = wa_s1 - 16'd1;
		end else if ((op_s1 & sm83_pkg::MASK_R16) == sm83_pkg::OP_ADD_HL) begin
			res.word_val = sum17[15:0];
			res.flags    = {flags_s1[sm83_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
		end else if ((op_s1 == sm83_pkg::OP_ADD_SP) || (op_s1 == sm83_pkg::OP_LD_HL_SP)) begin
			// signed 8-bit offset, flags come from the low byte add
			res.word_val = wa_s1 + {{8{opnd_s1[7]}}, opnd_s1};
			res.flags    = {2'b00, sp_nib[4], sp_lo[8]};
		end else if (((op_s1 >= sm83_pkg::OP_ALU_LO) && (op_s1 <= sm83_pkg::OP_ALU_HI)) ||
				((op_s1 & sm83_pkg::MASK_R8) == sm83_pkg::OP_ALU_IMM)) begin
			case (sel)
				sm83_pkg::ALU_ADD, sm83_pkg::ALU_ADC: begin
					r8  = sum9[7:0];
					h_f = nib_add[4];
					c_f = sum9[8];
				end
				sm83_pkg::ALU_SUB, sm83_pkg::ALU_SBC, sm83_pkg::ALU_CP: begin
					r8  = diff9[7:0];
					n_f = 1'b1;
					h_f = h_sub;
					c_f = diff9[8];
				end
				sm83_pkg::ALU_AND: begin
					r8  = acc_s1 & opnd_s1;
					h_f = 1'b1;
				end
				sm83_pkg::ALU_XOR: r8 = acc_s1 ^ opnd_s1;
				default:           r8 = acc_s1 | opnd_s1;
			endcase
			res.byte_val = (sel == sm83_pkg::ALU_CP) ? acc_s1 : r8;
			res.flags    = {r8 == 8'd0, n_f, h_f, c_f};
		end else if (((op_s1 & sm83_pkg::MASK_CC) == sm83_pkg::OP_JR_CC) ||
				((op_s1 & sm83_pkg::MASK_CC) == sm83_pkg::OP_RET_CC) ||
				((op_s1 & sm83_pkg::MASK_CC) == sm83_pkg::OP_JP_CC) ||
				((op_s1 & sm83_pkg::MASK_CC) == sm83_pkg::OP_CALL_CC)) begin
			case (sm83_pkg::cc_sel_t'(op_s1[4:3]))
				sm83_pkg::CC_NZ: res.cond = ~flags_s1[sm83_pkg::FLAG_Z];
				sm83_pkg::CC_Z:  res.cond = flags_s1[sm83_pkg::FLAG_Z];
				sm83_pkg::CC_NC: res.cond = ~flags_s1[sm83_pkg::FLAG_C];
				default:         res.cond = flags_s1[sm83_pkg::FLAG_C];
			endcase
		end else if ((op_s1 == sm83_pkg::OP_JR) || (op_s1 == sm83_pkg::OP_JP) ||
				(op_s1 == sm83_pkg::OP_RET) || (op_s1 == sm83_pkg::OP_CALL)) begin
			res.cond = 1'b1;
		end else begin
			res.unsup = 1'b1;
		end
	end

	assign out_valid   = valid_s2;
	assign result_byte = res_s2.byte_val;
	assign result_word = res_s2.word_val;
	assign flags_out   = res_s2.flags;
	assign cond_met    = res_s2.cond;
	assign unsupported = res_s2.unsup;

	`ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, valid_s1, "accepted word not held in input stage")
	`ASSERT_NEXT(a_s1_moves_to_s2, valid_s1 && load_s2, out_valid, "input stage word lost before result register")
	`ASSERT_ALWAYS(a_unsup_clean, !(out_valid && unsupported) || (!cond_met && result_byte == 8'd0 && result_word == 16'd0), "unsupported opcode produced a result")

endmodule

FILE: test/sm83_alu_flag_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_alu_flag_unit_test
// self-checking bench for the sm83 alu/flag unit: a directed table of opcodes
// and corner values, then random words over both opcode pages, all compared
// field by field against hand-written values or an in-bench predictor under
// random stalls on both sides
module sm83_alu_flag_unit_test;

	localparam int RAND_ITEMS   = 500;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 1000;

	localparam logic [7:0] OP_NOP    = 8'h00;
	localparam logic [7:0] OP_PREFIX = 8'hcb;
	localparam logic [2:0] REG_B     = 3'd0;
	localparam logic [2:0] REG_A     = 3'd7;
	localparam logic [1:0] PAIR_HL   = 2'd2;
	localparam logic [1:0] PAIR_SP   = 2'd3;

	typedef struct packed {
		logic [7:0]  opcode;
		logic        cb;
		logic [7:0]  acc;
		logic [3:0]  flags;
		logic [7:0]  opnd;
		logic [15:0] pair_a;
		logic [15:0] pair_b;
	} alu_req_t;

	typedef struct packed {
		alu_req_t          req;
		logic              known;
		sm83_pkg::result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  result_byte;
	logic [15:0] result_word;
	logic [3:0]  flags_out;
	logic        cond_met;
	logic        unsupported;
	alu_req_t    cur_req;
	sm83_pkg::result_t want_now;

	sm83_pkg::result_t pending_results [$];
	dir_row_t dir_table [$];
	int       send_idle = 19;
	int       recv_idle = 85;
	int       mismatches = 0;
	int       stall_cycles;
	bit       hold_req = 1'b0;

	sm83_alu_flag_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (cur_req.opcode),
		.cb_page    (cur_req.cb),
		.acc        (cur_req.acc),
		.flags_in   (cur_req.flags),
		.operand    (cur_req.opnd),
		.wide_a     (cur_req.pair_a),
		.wide_b     (cur_req.pair_b),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_byte(result_byte),
		.result_word(result_word),
		.flags_out  (flags_out),
		.cond_met   (cond_met),
		.unsupported(unsupported)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// opcode builders: y field in bits 5:3, register pair in bits 5:4
	function automatic logic [7:0] with_y(logic [7:0] base, logic [2:0] y);
		return base | {2'b00, y, 3'b000};
	endfunction

	function automatic logic [7:0] with_pair(logic [7:0] base, logic [1:0] p);
		return base | {2'b00, p, 4'b0000};
	endfunction

	function automatic logic [7:0] cb_code(sm83_pkg::cb_grp_t g, logic [2:0] y,
			logic [2:0] rsel);
		return {g, y, rsel};
	endfunction

	// prefixed-page op on one byte, returns {value, flags}
	function automatic logic [11:0] cb_outcome(logic [7:0] op, logic [7:0] v, logic [3:0] f);
		logic [7:0] res;
		logic       carry;
		case (sm83_pkg::cb_grp_t'(op[7:6]))
			sm83_pkg::CB_BIT: return {v, ~v[op[5:3]], 1'b0, 1'b1, f[sm83_pkg::FLAG_C]};
			sm83_pkg::CB_RES: return {v & ~(8'd1 << op[5:3]), f};
			sm83_pkg::CB_SET: return {v | (8'd1 << op[5:3]), f};
			default: begin
				case (sm83_pkg::rot_sel_t'(op[5:3]))
					sm83_pkg::RS_RLC: begin
						carry = v[7];
						res = {v[6:0], v[7]};
					end
					sm83_pkg::RS_RRC: begin
						carry = v[0];
						res = {v[0], v[7:1]};
					end
					sm83_pkg::RS_RL: begin
						carry = v[7];
						res = {v[6:0], f[sm83_pkg::FLAG_C]};
					end
					sm83_pkg::RS_RR: begin
						carry = v[0];
						res = {f[sm83_pkg::FLAG_C], v[7:1]};
					end
					sm83_pkg::RS_SLA: begin
						carry = v[7];
						res = v << 1;
					end
					sm83_pkg::RS_SRA: begin
						carry = v[0];
						res = {v[7], v[7:1]};
					end
					sm83_pkg::RS_SWAP: begin
						carry = 1'b0;
						res = {v[3:0], v[7:4]};
					end
					default: begin
						carry = v[0];
						res = v >> 1;
					end
				endcase
				return {res, res == 8'h00, 1'b0, 1'b0, carry};
			end
		endcase
	endfunction

	// accumulator op, returns {new a (a itself for cp), flags}
	function automatic logic [11:0] acc_outcome(sm83_pkg::alu_sel_t sel, logic [7:0] a,
			logic [7:0] b, logic [3:0] f);
		int unsigned ci;
		int unsigned sum;
		logic [7:0]  res;
		logic        half;
		logic        carry;
		logic        sub;
		ci = f[sm83_pkg::FLAG_C];
		sub = 1'b0;
		case (sel)
			sm83_pkg::ALU_ADD, sm83_pkg::ALU_ADC: begin
				if (sel == sm83_pkg::ALU_ADD)
					ci = 0;
				sum = a + b + ci;
				half = (a[3:0] + b[3:0] + ci) > 15;
				carry = sum[8];
				res = sum[7:0];
			end
			sm83_pkg::ALU_SUB, sm83_pkg::ALU_SBC, sm83_pkg::ALU_CP: begin
				if (sel != sm83_pkg::ALU_SBC)
					ci = 0;
				res = 8'(a - b - ci);
				half = a[3:0] < (b[3:0] + ci);
				carry = a < (b + ci);
				sub = 1'b1;
			end
			sm83_pkg::ALU_AND: begin
				res = a & b;
				half = 1'b1;
				carry = 1'b0;
			end
			sm83_pkg::ALU_XOR: begin
				res = a ^ b;
				half = 1'b0;
				carry = 1'b0;
			end
			default: begin
				res = a | b;
				half = 1'b0;
				carry = 1'b0;
			end
		endcase
		return {(sel == sm83_pkg::ALU_CP) ? a : res, res == 8'h00, sub, half, carry};
	endfunction

	function automatic sm83_pkg::result_t alu_outcome(alu_req_t q);
		sm83_pkg::result_t r;
		logic [11:0] bf;
		logic [7:0]  adj;
		logic        carry;
		logic        half;
		r = '0;
		r.flags = q.flags;
		if (q.cb) begin
			bf = cb_outcome(q.opcode, q.opnd, q.flags);
			r.byte_val = bf[11:4];
			r.flags = bf[3:0];
		end else if ((q.opcode & sm83_pkg::MASK_R8) == sm83_pkg::OP_INC_R8) begin
			r.byte_val = q.opnd + 8'd1;
			r.flags = {r.byte_val == 8'h00, 1'b0, q.opnd[3:0] == 4'hf,
				q.flags[sm83_pkg::FLAG_C]};
		end else if ((q.opcode & sm83_pkg::MASK_R8) == sm83_pkg::OP_DEC_R8) begin
			r.byte_val = q.opnd - 8'd1;
			r.flags = {r.byte_val == 8'h00, 1'b1, q.opnd[3:0] == 4'h0,
				q.flags[sm83_pkg::FLAG_C]};
		end else if (q.opcode == sm83_pkg::OP_DAA) begin
			adj = 8'h00;
			carry = q.flags[sm83_pkg::FLAG_C];
			if (q.flags[sm83_pkg::FLAG_H] ||
					(!q.flags[sm83_pkg::FLAG_N] && q.acc[3:0] > sm83_pkg::DAA_LO_MAX))
				adj |= sm83_pkg::DAA_LO_ADJ;
			if (carry || (!q.flags[sm83_pkg::FLAG_N] && q.acc > sm83_pkg::DAA_HI_MAX)) begin
				adj |= sm83_pkg::DAA_HI_ADJ;
				carry = 1'b1;
			end
			r.byte_val = q.flags[sm83_pkg::FLAG_N] ? q.acc - adj : q.acc + adj;
			r.flags = {r.byte_val == 8'h00, q.flags[sm83_pkg::FLAG_N], 1'b0, carry};
		end else if (q.opcode == sm83_pkg::OP_RLCA || q.opcode == sm83_pkg::OP_RRCA ||
				q.opcode == sm83_pkg::OP_RLA || q.opcode == sm83_pkg::OP_RRA) begin
			// same rotate as the prefixed page, but z is always cleared
			bf = cb_outcome(q.opcode, q.acc, q.flags);
			r.byte_val = bf[11:4];
			r.flags = {3'b000, bf[0]};
		end else if (q.opcode == sm83_pkg::OP_CPL) begin
			r.byte_val = ~q.acc;
			r.flags = {q.flags[sm83_pkg::FLAG_Z], 1'b1, 1'b1, q.flags[sm83_pkg::FLAG_C]};
		end else if (q.opcode == sm83_pkg::OP_SCF) begin
			r.byte_val = q.acc;
			r.flags = {q.flags[sm83_pkg::FLAG_Z], 1'b0, 1'b0, 1'b1};
		end else if (q.opcode == sm83_pkg::OP_CCF) begin
			r.byte_val = q.acc;
			r.flags = {q.flags[sm83_pkg::FLAG_Z], 1'b0, 1'b0, ~q.flags[sm83_pkg::FLAG_C]};
		end else if ((q.opcode & sm83_pkg::MASK_R16) == sm83_pkg::OP_INC_R16) begin
			r.word_val = q.pair_a + 16'd1;
		end else if ((q.opcode & sm83_pkg::MASK_R16) == sm83_pkg::OP_DEC_R16) begin
			r.word_val = q.pair_a - 16'd1;
		end else if ((q.opcode & sm83_pkg::MASK_R16) == sm83_pkg::OP_ADD_HL) begin
			half = (int'(q.pair_a[11:0]) + int'(q.pair_b[11:0])) > 'hfff;
			carry = (int'(q.pair_a) + int'(q.pair_b)) > 'hffff;
			r.word_val = q.pair_a + q.pair_b;
			r.flags = {q.flags[sm83_pkg::FLAG_Z], 1'b0, half, carry};
		end else if (q.opcode == sm83_pkg::OP_ADD_SP || q.opcode == sm83_pkg::OP_LD_HL_SP) begin
			// flags come from the unsigned low-byte add, the sum uses the signed offset
			half = (int'(q.pair_a[3:0]) + int'(q.opnd[3:0])) > 'hf;
			carry = (int'(q.pair_a[7:0]) + int'(q.opnd)) > 'hff;
			r.word_val = q.pair_a + {{8{q.opnd[7]}}, q.opnd};
			r.flags = {1'b0, 1'b0, half, carry};
		end else if ((q.opcode >= sm83_pkg::OP_ALU_LO && q.opcode <= sm83_pkg::OP_ALU_HI) ||
				(q.opcode & sm83_pkg::MASK_R8) == sm83_pkg::OP_ALU_IMM) begin
			bf = acc_outcome(sm83_pkg::alu_sel_t'(q.opcode[5:3]), q.acc, q.opnd, q.flags);
			r.byte_val = bf[11:4];
			r.flags = bf[3:0];
		end else if ((q.opcode & sm83_pkg::MASK_CC) == sm83_pkg::OP_JR_CC ||
				(q.opcode & sm83_pkg::MASK_CC) == sm83_pkg::OP_RET_CC ||
				(q.opcode & sm83_pkg::MASK_CC) == sm83_pkg::OP_JP_CC ||
				(q.opcode & sm83_pkg::MASK_CC) == sm83_pkg::OP_CALL_CC) begin
			case (sm83_pkg::cc_sel_t'(q.opcode[4:3]))
				sm83_pkg::CC_NZ: r.cond = !q.flags[sm83_pkg::FLAG_Z];
				sm83_pkg::CC_Z:  r.cond = q.flags[sm83_pkg::FLAG_Z];
				sm83_pkg::CC_NC: r.cond = !q.flags[sm83_pkg::FLAG_C];
				default:         r.cond = q.flags[sm83_pkg::FLAG_C];
			endcase
		end else if (q.opcode == sm83_pkg::OP_JR || q.opcode == sm83_pkg::OP_JP ||
				q.opcode == sm83_pkg::OP_RET || q.opcode == sm83_pkg::OP_CALL) begin
			r.cond = 1'b1;
		end else begin
			r.unsup = 1'b1;
		end
		return r;
	endfunction

	// known = 0 means the row is checked against the predictor
	function automatic dir_row_t dir_row(logic [7:0] op, logic cb, logic [7:0] a, logic [3:0] f,
			logic [7:0] v, logic [15:0] pa, logic [15:0] pb, logic known,
			sm83_pkg::result_t want);
		return {op, cb, a, f, v, pa, pb, known, want};
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_pair();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hffff;
			2:       return 16'h0fff;
			3:       return 16'h00ff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic send_req(alu_req_t q, sm83_pkg::result_t want);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cur_req  <= q;
		want_now <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// scoreboard: check the outgoing word first, then queue the incoming one
	always @(posedge clk) begin
		sm83_pkg::result_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result word with nothing pending");
					mismatches++;
				end else begin
					exp_r = pending_results.pop_front();
					check_field("result_byte", exp_r.byte_val, result_byte);
					check_field("result_word", exp_r.word_val, result_word);
					check_field("flags_out", exp_r.flags, flags_out);
					check_field("cond_met", exp_r.cond, cond_met);
					check_field("unsupported", exp_r.unsup, unsupported);
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(want_now);
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		alu_req_t q;
		int       i;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		cur_req  <= '0;
		want_now <= '0;

		dir_table = '{
			dir_row(OP_NOP, 1'b0, 8'hff, 4'b1011, 8'hff, 16'hffff, 16'hffff,
				1'b1, {8'h00, 16'h0000, 4'b1011, 1'b0, 1'b1}),
			// prefix byte seen on the main page does nothing here
			dir_row(OP_PREFIX, 1'b0, 8'h12, 4'b0101, 8'h34, 16'h5678, 16'h9abc,
				1'b1, {8'h00, 16'h0000, 4'b0101, 1'b0, 1'b1}),
			dir_row(with_y(sm83_pkg::OP_INC_R8, REG_A), 1'b0, 8'hff, 4'b0001, 8'hff,
				16'h0000, 16'h0000, 1'b1, {8'h00, 16'h0000, 4'b1011, 1'b0, 1'b0}),
			dir_row(sm83_pkg::OP_DEC_R8, 1'b0, 8'h00, 4'b0000, 8'h01, 16'h0000, 16'h0000,
				1'b1, {8'h00, 16'h0000, 4'b1100, 1'b0, 1'b0}),
			dir_row(sm83_pkg::OP_DAA, 1'b0, 8'h9a, 4'b0000, 8'h00, 16'h0000, 16'h0000,
				1'b0, '0),
			dir_row(sm83_pkg::OP_DAA, 1'b0, 8'h00, 4'b0111, 8'h00, 16'h0000, 16'h0000,
				1'b0, '0),
			dir_row(with_y(sm83_pkg::OP_ALU_LO, sm83_pkg::ALU_ADD), 1'b0, 8'hff, 4'b0000,
				8'h01, 16'h0000, 16'h0000, 1'b1, {8'h00, 16'h0000, 4'b1011, 1'b0, 1'b0}),
			dir_row(with_y(sm83_pkg::OP_ALU_LO, sm83_pkg::ALU_SBC), 1'b0, 8'h10, 4'b0001,
				8'h0f, 16'h0000, 16'h0000, 1'b0, '0),
			dir_row(with_y(sm83_pkg::OP_ALU_IMM, sm83_pkg::ALU_SUB), 1'b0, 8'h00, 4'b0000,
				8'h01, 16'h0000, 16'h0000, 1'b1, {8'hff, 16'h0000, 4'b0111, 1'b0, 1'b0}),
			dir_row(with_y(sm83_pkg::OP_ALU_LO, sm83_pkg::ALU_AND), 1'b0, 8'hf0, 4'b0001,
				8'h0f, 16'h0000, 16'h0000, 1'b1, {8'h00, 16'h0000, 4'b1010, 1'b0, 1'b0}),
			dir_row(with_y(sm83_pkg::OP_ALU_LO, sm83_pkg::ALU_XOR) | REG_A, 1'b0, 8'h55,
				4'b1111, 8'h55, 16'h0000, 16'h0000,
				1'b1, {8'h00, 16'h0000, 4'b1000, 1'b0, 1'b0}),
			dir_row(with_y(sm83_pkg::OP_ALU_IMM, sm83_pkg::ALU_OR), 1'b0, 8'h80, 4'b1111,
				8'h01, 16'h0000, 16'h0000, 1'b0, '0),
			// cp leaves a untouched in the byte result
			dir_row(with_y(sm83_pkg::OP_ALU_IMM, sm83_pkg::ALU_CP), 1'b0, 8'h42, 4'b0000,
				8'h42, 16'h0000, 16'h0000, 1'b1, {8'h42, 16'h0000, 4'b1100, 1'b0, 1'b0}),
			dir_row(sm83_pkg::OP_RLCA, 1'b0, 8'h80, 4'b1110, 8'h00, 16'h0000, 16'h0000,
				1'b0, '0),
			dir_row(sm83_pkg::OP_CPL, 1'b0, 8'h5a, 4'b0000, 8'h00, 16'h0000, 16'h0000,
				1'b0, '0),
			dir_row(sm83_pkg::OP_SCF, 1'b0, 8'h33, 4'b1110, 8'h00, 16'h0000, 16'h0000,
				1'b0, '0),
			dir_row(sm83_pkg::OP_CCF, 1'b0, 8'h33, 4'b0001, 8'h00, 16'h0000, 16'h0000,
				1'b0, '0),
			dir_row(sm83_pkg::OP_INC_R16, 1'b0, 8'h00, 4'b1111, 8'h00, 16'hffff, 16'h0000,
				1'b1, {8'h00, 16'h0000, 4'b1111, 1'b0, 1'b0}),
			dir_row(with_pair(sm83_pkg::OP_DEC_R16, PAIR_SP), 1'b0, 8'h00, 4'b0000, 8'h00,
				16'h0000, 16'h0000, 1'b1, {8'h00, 16'hffff, 4'b0000, 1'b0, 1'b0}),
			dir_row(with_pair(sm83_pkg::OP_ADD_HL, PAIR_HL), 1'b0, 8'h00, 4'b1000, 8'h00,
				16'hffff, 16'hffff, 1'b1, {8'h00, 16'hfffe, 4'b1011, 1'b0, 1'b0}),
			dir_row(sm83_pkg::OP_ADD_SP, 1'b0, 8'h00, 4'b1111, 8'h80, 16'h00ff, 16'h0000,
				1'b0, '0),
			dir_row(sm83_pkg::OP_LD_HL_SP, 1'b0, 8'h00, 4'b0000, 8'h01, 16'hffff, 16'h0000,
				1'b0, '0),
			dir_row(cb_code(sm83_pkg::CB_ROT, sm83_pkg::RS_SWAP, REG_A), 1'b1, 8'hf0,
				4'b1111, 8'hf0, 16'h0000, 16'h0000, 1'b0, '0),
			dir_row(cb_code(sm83_pkg::CB_BIT, 3'd7, REG_A), 1'b1, 8'h7f, 4'b0000, 8'h7f,
				16'h0000, 16'h0000, 1'b1, {8'h7f, 16'h0000, 4'b1010, 1'b0, 1'b0}),
			dir_row(cb_code(sm83_pkg::CB_SET, 3'd7, REG_B), 1'b1, 8'h00, 4'b0110, 8'h00,
				16'h0000, 16'h0000, 1'b1, {8'h80, 16'h0000, 4'b0110, 1'b0, 1'b0}),
			dir_row(with_y(sm83_pkg::OP_JR_CC, sm83_pkg::CC_NZ), 1'b0, 8'h00, 4'b1000, 8'h00,
				16'h0000, 16'h0000, 1'b1, {8'h00, 16'h0000, 4'b1000, 1'b0, 1'b0}),
			dir_row(with_y(sm83_pkg::OP_RET_CC, sm83_pkg::CC_C), 1'b0, 8'h00, 4'b0001, 8'h00,
				16'h0000, 16'h0000, 1'b1, {8'h00, 16'h0000, 4'b0001, 1'b1, 1'b0}),
			dir_row(sm83_pkg::OP_JP, 1'b0, 8'h00, 4'b0000, 8'h00, 16'h0000, 16'h0000,
				1'b1, {8'h00, 16'h0000, 4'b0000, 1'b1, 1'b0})
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[k])
			send_req(dir_table[k].req,
				dir_table[k].known ? dir_table[k].want : alu_outcome(dir_table[k].req));

		for (i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS / 3) begin
				send_idle = 85;
				recv_idle = 19;
			end else if (i == 2 * RAND_ITEMS / 3) begin
				// no idling from here on, but first stall the output long enough to back up
				send_idle = 0;
				recv_idle = 0;
				hold_req = 1'b1;
			end
			q.cb     = ($urandom_range(3) == 0);
			q.opcode = 8'($urandom);
			q.acc    = rand_byte();
			q.flags  = 4'($urandom);
			q.opnd   = rand_byte();
			q.pair_a = rand_pair();
			q.pair_b = rand_pair();
			send_req(q, alu_outcome(q));
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/sm83_pkg.sv
hdl/sm83_alu_flag_unit.sv
test/sm83_alu_flag_unit_test.sv
